@@ hdl/pdmm_pkg.sv @@
// Shared types and constants of the pixel deviation motion mask unit.
// No dependencies; pdmm_root and the top unit refer to this package, pdmm_ram does not.
package pdmm_pkg;

	localparam int SUM_W = 22;
	localparam int PIX_W = 8;
	localparam int DIV_W = 8;
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	typedef enum logic [1:0] {
		CMD_TRAIN  = 2'd0,
		CMD_DETECT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_FRAMES = 2'd0,
		REG_GAIN   = 2'd1,
		REG_INVERT = 2'd2
	} reg_t;

	typedef struct packed {
		logic             vld;
		logic [PIX_W-1:0] diff;
	} side_t;

endpackage

@@ hdl/pdmm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pdmm_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 65536
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/pdmm_root.sv @@
// Pipelined rounded square root of sum / divisor, exact in integers.
// Depends on pdmm_pkg for widths and the sideband type.
module pdmm_root (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  pdmm_pkg::side_t              in_side,
	input  logic [pdmm_pkg::SUM_W-1:0]   in_sum,
	input  logic [pdmm_pkg::DIV_W-1:0]   in_div,
	output pdmm_pkg::side_t              out_side,
	output logic [7:0]                   out_root
);

	localparam int NUM_W = pdmm_pkg::SUM_W + 2;
	localparam int DIV_ST = NUM_W / 2;
	localparam int ROOT_W = NUM_W / 2;
	localparam int SQ_ST = ROOT_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int DW = pdmm_pkg::DIV_W;

	logic             div_vld_s  [DIV_ST+1];
	logic [7:0]       div_diff_s [DIV_ST+1];
	logic [NUM_W-1:0] div_num_s  [DIV_ST+1];
	logic [DW-1:0]    div_rem_s  [DIV_ST+1];
	logic [DW-1:0]    div_d_s    [DIV_ST+1];
	logic [NUM_W-1:0] div_num_n  [DIV_ST];
	logic [DW-1:0]    div_rem_n  [DIV_ST];

	logic              sq_vld_s  [SQ_ST+1];
	logic [7:0]        sq_diff_s [SQ_ST+1];
	logic [NUM_W-1:0]  sq_rad_s  [SQ_ST+1];
	logic [REM_W-1:0]  sq_rem_s  [SQ_ST+1];
	logic [ROOT_W-1:0] sq_root_s [SQ_ST+1];
	logic              sq_ex_s   [SQ_ST+1];
	logic [NUM_W-1:0]  sq_rad_n  [SQ_ST];
	logic [REM_W-1:0]  sq_rem_n  [SQ_ST];
	logic [ROOT_W-1:0] sq_root_n [SQ_ST];

	logic              vld_s;
	logic [7:0]        diff_s;
	logic [7:0]        root_s;
	logic [ROOT_W-1:0] isq;
	logic [ROOT_W-1:0] half;
	logic              exact;
	logic [7:0]        root_n;

	always_comb begin
		logic [DW-1:0]    rem_t;
		logic [NUM_W-1:0] num_t;
		logic [DW:0]      tr;
		logic             ge;
		for (int i = 0; i < DIV_ST; i++) begin
			rem_t = div_rem_s[i];
			num_t = div_num_s[i];
			for (int j = 0; j < 2; j++) begin
				tr = {rem_t, num_t[NUM_W-1]};
				ge = (tr >= {1'b0, div_d_s[i]});
				rem_t = ge ? DW'(tr - {1'b0, div_d_s[i]}) : tr[DW-1:0];
				num_t = {num_t[NUM_W-2:0], ge};
			end
			div_rem_n[i] = rem_t;
			div_num_n[i] = num_t;
		end
	end

	always_comb begin
		logic [REM_W-1:0]  rem_t;
		logic [NUM_W-1:0]  rad_t;
		logic [ROOT_W-1:0] root_t;
		logic [REM_W+1:0]  t;
		logic [REM_W+1:0]  trial;
		logic              ge;
		for (int i = 0; i < SQ_ST; i++) begin
			rem_t = sq_rem_s[i];
			rad_t = sq_rad_s[i];
			root_t = sq_root_s[i];
			for (int j = 0; j < 2; j++) begin
				t = {rem_t, rad_t[NUM_W-1:NUM_W-2]};
				trial = {2'b00, root_t, 2'b01};
				ge = (t >= trial);
				rem_t = ge ? REM_W'(t - trial) : REM_W'(t);
				root_t = {root_t[ROOT_W-2:0], ge};
				rad_t = {rad_t[NUM_W-3:0], 2'b00};
			end
			sq_rem_n[i] = rem_t;
			sq_rad_n[i] = rad_t;
			sq_root_n[i] = root_t;
		end
	end

	assign isq = sq_root_s[SQ_ST];
	assign half = ROOT_W'(({1'b0, isq} + 1'b1) >> 1);
	assign exact = sq_ex_s[SQ_ST] && (sq_rem_s[SQ_ST] == '0);

	always_comb begin
		if (half > ROOT_W'(255)) begin
			root_n = 8'd255;
		end else if (exact && isq[0] && half[0]) begin
			root_n = 8'(half - 1'b1);
		end else begin
			root_n = half[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_ST; i++) begin
				div_vld_s[i] <= 1'b0;
			end
			for (int i = 0; i <= SQ_ST; i++) begin
				sq_vld_s[i] <= 1'b0;
			end
			vld_s <= 1'b0;
		end else if (en) begin
			div_vld_s[0] <= in_side.vld;
			for (int i = 0; i < DIV_ST; i++) begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
			sq_vld_s[0] <= div_vld_s[DIV_ST];
			for (int i = 0; i < SQ_ST; i++) begin
				sq_vld_s[i+1] <= sq_vld_s[i];
			end
			vld_s <= sq_vld_s[SQ_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_diff_s[0] <= in_side.diff;
			div_num_s[0] <= {in_sum, 2'b00};
			div_rem_s[0] <= '0;
			div_d_s[0] <= in_div;
			for (int i = 0; i < DIV_ST; i++) begin
				div_diff_s[i+1] <= div_diff_s[i];
				div_num_s[i+1] <= div_num_n[i];
				div_rem_s[i+1] <= div_rem_n[i];
				div_d_s[i+1] <= div_d_s[i];
			end
			sq_diff_s[0] <= div_diff_s[DIV_ST];
			sq_rad_s[0] <= div_num_s[DIV_ST];
			sq_rem_s[0] <= '0;
			sq_root_s[0] <= '0;
			sq_ex_s[0] <= (div_rem_s[DIV_ST] == '0);
			for (int i = 0; i < SQ_ST; i++) begin
				sq_diff_s[i+1] <= sq_diff_s[i];
				sq_rad_s[i+1] <= sq_rad_n[i];
				sq_rem_s[i+1] <= sq_rem_n[i];
				sq_root_s[i+1] <= sq_root_n[i];
				sq_ex_s[i+1] <= sq_ex_s[i];
			end
			diff_s <= sq_diff_s[SQ_ST];
			root_s <= root_n;
		end
	end

	assign out_side.vld = vld_s;
	assign out_side.diff = diff_s;
	assign out_root = root_s;

endmodule

@@ hdl/pixel_deviation_motion_mask_unit.sv @@
// Per-pixel motion mask: deviation sums in a RAM, threshold by rounded square root.
// Throughput: one word per cycle while pix_stall is low; train and clear words update
// the RAM read-modify-write in one stage.
// After reset the RAM is cleared one entry per cycle, all MAX_PIXELS entries, while pix_stall is high.
// Depends on pdmm_pkg, pdmm_ram and pdmm_root.
module pixel_deviation_motion_mask_unit #(
	parameter int MAX_PIXELS = 65536,
	parameter int MAX_FRAMES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdmm_pkg::CFG_AW-1:0]   paddr,
	input  logic [pdmm_pkg::CFG_DW-1:0]   pwdata,
	output logic [pdmm_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [1:0]                    command,
	input  logic [15:0]                   pixel_index,
	input  logic [7:0]                    frame_pixel,
	input  logic [7:0]                    background_pixel,
	input  logic [7:0]                    diff_pixel,
	output logic                          mask_valid,
	input  logic                          mask_stall,
	output logic [7:0]                    mask_pixel,
	output logic [7:0]                    threshold_value
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int SW = pdmm_pkg::SUM_W;

	logic [6:0] frames_q;
	logic [7:0] gain_q;
	logic       invert_q;
	logic       clr_busy_q;
	logic [AW-1:0] clr_q;

	logic adv;
	logic [31:0] idx_ext;
	logic [7:0]  absd;

	logic          vld_s1;
	logic [1:0]    cmd_s1;
	logic          ok_s1;
	logic [AW-1:0] addr_s1;
	logic [15:0]   sq_s1;
	logic [7:0]    diff_s1;

	logic [SW-1:0] rdata;
	logic [SW-1:0] cur;
	logic [SW:0]   add;
	logic [SW-1:0] new_sum;
	logic          upd;

	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [SW-1:0] wr_data_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;

	logic [8:0]    f_cl;
	logic [pdmm_pkg::DIV_W-1:0] divisor;

	pdmm_pkg::side_t side_in;
	pdmm_pkg::side_t side_out;
	logic [7:0]      root;

	logic        prod_vld_s;
	logic [7:0]  prod_diff_s;
	logic [15:0] prod_s;
	logic [7:0]  thr;
	logic        fg;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= 7'd16;
			gain_q <= 8'd1;
			invert_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				pdmm_pkg::REG_FRAMES: frames_q <= pwdata[6:0];
				pdmm_pkg::REG_GAIN:   gain_q <= pwdata[7:0];
				pdmm_pkg::REG_INVERT: invert_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pdmm_pkg::REG_FRAMES: prdata = {25'd0, frames_q};
			pdmm_pkg::REG_GAIN:   prdata = {24'd0, gain_q};
			pdmm_pkg::REG_INVERT: prdata = {31'd0, invert_q};
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(MAX_PIXELS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign adv = !(mask_valid && mask_stall);
	assign pix_stall = clr_busy_q || !adv;

	assign idx_ext = {16'd0, pixel_index};
	assign absd = (frame_pixel > background_pixel) ? (frame_pixel - background_pixel)
		: (background_pixel - frame_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			wr_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid && !clr_busy_q;
			wr_vld_q <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= command;
			ok_s1 <= (idx_ext < 32'(MAX_PIXELS));
			addr_s1 <= idx_ext[AW-1:0];
			sq_s1 <= 16'(absd) * 16'(absd);
			diff_s1 <= diff_pixel;
			wr_addr_q <= addr_s1;
			wr_data_q <= new_sum;
		end
	end

	pdmm_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_PIXELS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv),
		.raddr(idx_ext[AW-1:0]),
		.rdata(rdata)
	);

	assign cur = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata;
	assign add = {1'b0, cur} + {{(SW+1-16){1'b0}}, sq_s1};

	always_comb begin
		if (cmd_s1 == pdmm_pkg::CMD_CLEAR) begin
			new_sum = '0;
		end else if (add[SW]) begin
			new_sum = '1;
		end else begin
			new_sum = add[SW-1:0];
		end
	end

	assign upd = vld_s1 && ok_s1
		&& ((cmd_s1 == pdmm_pkg::CMD_TRAIN) || (cmd_s1 == pdmm_pkg::CMD_CLEAR));

	assign ram_we = clr_busy_q || (adv && upd);
	assign ram_waddr = clr_busy_q ? clr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : new_sum;

	always_comb begin
		if (frames_q < 7'd2) begin
			f_cl = 9'd2;
		end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
			f_cl = 9'(MAX_FRAMES);
		end else begin
			f_cl = {2'b00, frames_q};
		end
	end

	assign divisor = pdmm_pkg::DIV_W'(f_cl - 9'd1);

	assign side_in.vld = vld_s1 && (cmd_s1 == pdmm_pkg::CMD_DETECT);
	assign side_in.diff = diff_s1;

	pdmm_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_side (side_in),
		.in_sum  (ok_s1 ? cur : '0),
		.in_div  (divisor),
		.out_side(side_out),
		.out_root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s <= 1'b0;
			mask_valid <= 1'b0;
		end else if (adv) begin
			prod_vld_s <= side_out.vld;
			mask_valid <= prod_vld_s;
		end
	end

	assign thr = (prod_s > 16'd255) ? 8'd255 : prod_s[7:0];
	assign fg = (prod_diff_s > thr) ^ invert_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s <= 16'(root) * 16'(gain_q);
			prod_diff_s <= side_out.diff;
			threshold_value <= thr;
			mask_pixel <= fg ? 8'd255 : 8'd0;
		end
	end

endmodule
